### rtl/gsd_pkg.sv
// Shared constants and types for the descending group sorter.
`default_nettype none
package gsd_pkg;

  localparam int GSD_CAPACITY = 13;
  localparam int KEY_W        = 8;

  typedef logic [KEY_W-1:0] key_t;

  // broadcast from control to every cell
  typedef struct packed {
    logic ins;
    logic shf;
    key_t key;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } gsd_state_t;

endpackage
`default_nettype wire

### rtl/gsd_if.sv
// Word channel interfaces of the descending group sorter.
`default_nettype none
interface gsd_in_if;
  import gsd_pkg::*;
  logic valid;
  logic ready;
  key_t key_value;
  logic group_end;
  modport source (output valid, key_value, group_end, input ready);
  modport sink   (input valid, key_value, group_end, output ready);
endinterface

interface gsd_out_if;
  import gsd_pkg::*;
  logic valid;
  logic ready;
  key_t sorted_value;
  logic run_last;
  logic overflow_flag;
  modport source (output valid, sorted_value, run_last, overflow_flag, input ready);
  modport sink   (input valid, sorted_value, run_last, overflow_flag, output ready);
endinterface
`default_nettype wire

### rtl/gsd_cell.sv
// One sorter cell: holds a key, inserts or shifts with its neighbors.
`default_nettype none
module gsd_cell (
  input  wire logic              clk,
  input  wire gsd_pkg::cell_ctl_t ctl,
  input  wire logic              occ,
  input  wire logic              prev_ge,
  input  wire gsd_pkg::key_t     prev_val,
  input  wire gsd_pkg::key_t     next_val,
  output gsd_pkg::key_t          val,
  output logic                   ge
);
  import gsd_pkg::*;

  key_t val_r;
  key_t val_nxt;

  // held key stays ahead of an equal new key
  assign ge  = occ && (val_r >= ctl.key);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (!ge) begin
        val_nxt = prev_ge ? ctl.key : prev_val;
      end
    end else if (ctl.shf) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

### rtl/gsd_ctrl.sv
// Sorter control: fill count, overflow tracking and group emission.
`default_nettype none
module gsd_ctrl #(
  parameter int GROUP_CAPACITY = gsd_pkg::GSD_CAPACITY,
  localparam int CW = $clog2(GROUP_CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire gsd_pkg::key_t      in_key,
  input  wire logic               in_group_end,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    run_last,
  output logic                    overflow_flag,
  output gsd_pkg::cell_ctl_t      ctl,
  output logic [CW-1:0]           fill
);
  import gsd_pkg::*;

  gsd_state_t    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          ovf_r, ovf_nxt;
  logic          full;
  logic          acc;

  assign full          = (fill_r == CW'(GROUP_CAPACITY));
  assign in_ready      = (state_r == ST_LOAD);
  assign acc           = in_valid && in_ready;
  assign out_valid     = (state_r == ST_EMIT);
  assign run_last      = (left_r == CW'(1));
  assign overflow_flag = ovf_r;
  assign fill          = fill_r;

  assign ctl.ins = acc && !full;
  assign ctl.shf = out_valid && out_ready;
  assign ctl.key = in_key;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    left_nxt  = left_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_LOAD: begin
        if (acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            fill_nxt = fill_r + CW'(1);
          end
          if (in_group_end) begin
            state_nxt = ST_EMIT;
            left_nxt  = full ? fill_r : fill_r + CW'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          left_nxt = left_r - CW'(1);
          if (run_last) begin
            state_nxt = ST_LOAD;
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
      left_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      left_r  <= left_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/group_sort_descending.sv
// Top level: grouped insertion sort, largest key first, on a row of cells.
// A key is inserted in the cycle it is accepted if a cell is free, one word
// per cycle; input stalls while a group streams out. Results start the cycle
// after the group's last word, one word per cycle while out_ready is high.
// Reset clears fill count, overflow and control; cell contents are not reset.
`default_nettype none
module group_sort_descending #(
  parameter int GROUP_CAPACITY = gsd_pkg::GSD_CAPACITY
) (
  input wire logic  clk,
  input wire logic  rst_n,
  gsd_in_if.sink    in_word,
  gsd_out_if.source out_word
);
  import gsd_pkg::*;

  localparam int CW = $clog2(GROUP_CAPACITY + 1);

  cell_ctl_t     ctl;
  logic [CW-1:0] fill;
  key_t          val [GROUP_CAPACITY];
  logic          ge  [GROUP_CAPACITY];

  gsd_ctrl #(.GROUP_CAPACITY(GROUP_CAPACITY)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_word.valid),
    .in_key       (in_word.key_value),
    .in_group_end (in_word.group_end),
    .in_ready     (in_word.ready),
    .out_valid    (out_word.valid),
    .out_ready    (out_word.ready),
    .run_last     (out_word.run_last),
    .overflow_flag(out_word.overflow_flag),
    .ctl          (ctl),
    .fill         (fill)
  );

  for (genvar i = 0; i < GROUP_CAPACITY; i++) begin : g_cell
    logic occ;
    logic p_ge;
    key_t p_val;
    key_t n_val;

    assign occ = (fill > CW'(i));
    if (i == 0) begin : g_first
      assign p_ge  = 1'b1;
      assign p_val = ctl.key;
    end else begin : g_mid
      assign p_ge  = ge[i-1];
      assign p_val = val[i-1];
    end
    if (i == GROUP_CAPACITY - 1) begin : g_tail
      assign n_val = val[i];
    end else begin : g_next
      assign n_val = val[i+1];
    end

    gsd_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (occ),
      .prev_ge (p_ge),
      .prev_val(p_val),
      .next_val(n_val),
      .val     (val[i]),
      .ge      (ge[i])
    );
  end

  assign out_word.sorted_value = val[0];

endmodule
`default_nettype wire
